@@ rtl/erfg_pkg.sv @@
// ============================================================================
// Expanding ring frame generator package
// Shared constants and helper functions for the ring sequence: phase
// codes, phase lengths, ring endpoints and the ring of a panel position.
// ============================================================================
package erfg_pkg;

   // Fade and dwell defaults.
   localparam int unsigned FADE_STEPS           = 16;
   localparam logic [15:0] DEFAULT_HOLD_FRAMES  = 16'd30;
   localparam logic [15:0] DEFAULT_CROSS_FRAMES = 16'd30;

   // Mix arithmetic constants.
   localparam logic [7:0]  MIX_FULL   = 8'd255;
   localparam logic [15:0] ROUND_BIAS = 16'd127;

   // Panel geometry.
   localparam logic [5:0] LAST_PIXEL = 6'd63;

   // Sequence phase codes.
   localparam logic [3:0] PH_FADE_IN   = 4'd0;
   localparam logic [3:0] PH_HOLD_ONE  = 4'd1;
   localparam logic [3:0] PH_OUT_12    = 4'd2;
   localparam logic [3:0] PH_OUT_23    = 4'd3;
   localparam logic [3:0] PH_OUT_34    = 4'd4;
   localparam logic [3:0] PH_HOLD_FOUR = 4'd5;
   localparam logic [3:0] PH_IN_43     = 4'd6;
   localparam logic [3:0] PH_IN_32     = 4'd7;
   localparam logic [3:0] PH_IN_21     = 4'd8;
   localparam logic [3:0] PH_HOLD_BACK = 4'd9;
   localparam logic [3:0] PH_FADE_OUT  = 4'd10;

   typedef logic [2:0] ring_type;

   // Fade phases ramp ring one in or out.
   function automatic logic is_fade(input logic [3:0] ph);
      return (ph == PH_FADE_IN) || (ph == PH_FADE_OUT);
   endfunction

   // Hold phases show one ring at full mix.
   function automatic logic is_hold(input logic [3:0] ph);
      return (ph == PH_HOLD_ONE) || (ph == PH_HOLD_FOUR) || (ph == PH_HOLD_BACK);
   endfunction

   // Phase following ph, wrapping after the fade out.
   function automatic logic [3:0] next_phase(input logic [3:0] ph);
      return (ph >= PH_FADE_OUT) ? PH_FADE_IN : ph + 4'd1;
   endfunction

   // Number of frames in a phase, using the effective dwell values.
   function automatic logic [16:0] phase_len(input logic [3:0] ph,
                                             input logic [15:0] inner_eff,
                                             input logic [15:0] step_eff);
      logic [16:0] len;
      if (is_fade(ph)) begin
         len = 17'(FADE_STEPS + 1);
      end else if (is_hold(ph)) begin
         len = {1'b0, inner_eff};
      end else begin
         len = {1'b0, step_eff} + 17'd1;
      end
      return len;
   endfunction

   // Ring that a crossfade leaves; holds use the same ring on both ends.
   function automatic ring_type ring_from(input logic [3:0] ph);
      ring_type r;
      case (ph)
         PH_OUT_23:    r = 3'd2;
         PH_OUT_34:    r = 3'd3;
         PH_HOLD_FOUR: r = 3'd4;
         PH_IN_43:     r = 3'd4;
         PH_IN_32:     r = 3'd3;
         PH_IN_21:     r = 3'd2;
         default:      r = 3'd1;
      endcase
      return r;
   endfunction

   // Ring that a crossfade enters.
   function automatic ring_type ring_to(input logic [3:0] ph);
      ring_type r;
      case (ph)
         PH_OUT_12:    r = 3'd2;
         PH_OUT_23:    r = 3'd3;
         PH_OUT_34:    r = 3'd4;
         PH_HOLD_FOUR: r = 3'd4;
         PH_IN_43:     r = 3'd3;
         PH_IN_32:     r = 3'd2;
         default:      r = 3'd1;
      endcase
      return r;
   endfunction

   // Distance of one axis coordinate from the central pair, columns 3 and 4.
   function automatic logic [1:0] axis_dist(input logic [2:0] c);
      logic [1:0] d;
      if (c < 3'd3) begin
         d = 2'(3'd3 - c);
      end else if (c > 3'd4) begin
         d = 2'(c - 3'd4);
      end else begin
         d = 2'd0;
      end
      return d;
   endfunction

   // Ring of a pixel: one plus its Chebyshev distance from the center block.
   function automatic ring_type ring_of(input logic [5:0] pos);
      logic [1:0] dx;
      logic [1:0] dy;
      dx = axis_dist(pos[2:0]);
      dy = axis_dist(pos[5:3]);
      return (dx > dy) ? {1'b0, dx} + 3'd1 : {1'b0, dy} + 3'd1;
   endfunction

endpackage

@@ rtl/expanding_ring_frame_generator_unit.sv @@
// ============================================================================
// Expanding ring frame generator unit
// Renders one 8x8 white frame per frame tick request and streams its 64
// pixel levels in row order, driving a looping fade and crossfade of rings.
// ============================================================================
//
//   Channel  Direction  Handshake              Payload
//   req_     in         req_valid / req_stall  req_frame_tick
//   rsp_     out        rsp_valid / rsp_stall  rsp_pixel_index, rsp_white, rsp_last
//   csr_     in         csr_valid / csr_ready  csr_index, csr_data
//
// A frame request passes through a setup state, an 8-step mix division
// (crossfades only), two rounded level divisions of one load and 8 steps each
// on the shared divider, 64 pixel loads and the output register. Result stalls
// hold the pixel loads, req_stall is high for the whole frame, and a request
// with frame_tick low is taken without starting a frame.
// Reset is synchronous and restores the register defaults.
module expanding_ring_frame_generator_unit (
   input  logic       clock,
   input  logic       reset,
   // Frame requests
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_frame_tick,
   // Pixel results
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [5:0] rsp_pixel_index,
   output logic [7:0] rsp_white,
   output logic       rsp_last,
   // Register writes
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [15:0] csr_data
);
   import erfg_pkg::*;

   // Sequencer state codes.
   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_MIX      = 3'd1;
   localparam logic [2:0] S_DIV_MIX  = 3'd2;
   localparam logic [2:0] S_LOAD_OLD = 3'd3;
   localparam logic [2:0] S_DIV_OLD  = 3'd4;
   localparam logic [2:0] S_LOAD_NEW = 3'd5;
   localparam logic [2:0] S_DIV_NEW  = 3'd6;
   localparam logic [2:0] S_EMIT     = 3'd7;

   // Register indexes.
   localparam logic [1:0] REG_HOLD_FRAMES  = 2'd0;
   localparam logic [1:0] REG_CROSS_FRAMES = 2'd1;
   localparam logic [1:0] REG_ACTIVE_LEVEL = 2'd2;
   localparam logic [1:0] REG_INNER_LEVEL  = 2'd3;

   logic [15:0] hold_frames_ff, hold_frames_in;
   logic [15:0] cross_frames_ff, cross_frames_in;
   logic [7:0]  active_level_ff, active_level_in;
   logic [7:0]  inner_level_ff, inner_level_in;

   logic [2:0]  state_ff, state_in;
   logic [3:0]  phase_ff, phase_in;
   logic [15:0] fc_ff, fc_in;
   logic [5:0]  pos_ff, pos_in;

   logic [7:0]  mix_ff, mix_in;
   logic [7:0]  old_mix_ff, old_mix_in;
   logic [7:0]  old_w_ff, old_w_in;
   logic [7:0]  new_w_ff, new_w_in;

   // Shared divider registers.
   logic [23:0] rem_ff, rem_in;
   logic [23:0] dsh_ff, dsh_in;
   logic [7:0]  quo_ff, quo_in;
   logic [2:0]  cnt_ff, cnt_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [5:0]  rsp_index_ff, rsp_index_in;
   logic [7:0]  rsp_white_ff, rsp_white_in;
   logic        rsp_last_ff, rsp_last_in;

   logic [15:0] inner_eff;
   logic [15:0] step_eff;
   logic        req_take;
   logic        csr_take;
   logic [3:0]  norm_phase;
   logic        div_ge;
   logic        div_done;
   logic        emit_load;
   logic [4:0]  fade_n;
   logic [7:0]  fade_mix;
   logic [15:0] scale_prod;
   ring_type    old_ring;
   ring_type    new_ring;
   ring_type    extent;
   ring_type    pix_ring;
   logic [7:0]  pix_white;
   logic [16:0] fc_next;

   assign inner_eff = (hold_frames_ff == 16'd0) ? DEFAULT_HOLD_FRAMES : hold_frames_ff;
   assign step_eff  = (cross_frames_ff == 16'd0) ? DEFAULT_CROSS_FRAMES : cross_frames_ff;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign csr_take  = csr_valid && csr_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_index = rsp_index_ff;
   assign rsp_white       = rsp_white_ff;
   assign rsp_last        = rsp_last_ff;

   // Unused phase codes fold back to the fade in.
   assign norm_phase = (phase_ff > PH_FADE_OUT) ? PH_FADE_IN : phase_ff;

   // Fade mix is n*255/FADE_STEPS, n counting down during the fade out.
   assign fade_n   = (phase_ff == PH_FADE_OUT) ? 5'(5'(FADE_STEPS) - fc_ff[4:0])
                                               : fc_ff[4:0];
   assign fade_mix = 8'(({8'd0, fade_n} * 13'(MIX_FULL)) / FADE_STEPS);

   // Rings of the current phase.
   always_comb begin
      if (is_fade(phase_ff)) begin
         old_ring = 3'd0;
         new_ring = 3'd1;
         extent   = 3'd1;
      end else if (is_hold(phase_ff)) begin
         old_ring = 3'd0;
         new_ring = ring_to(phase_ff);
         extent   = ring_to(phase_ff);
      end else begin
         old_ring = ring_from(phase_ff);
         new_ring = ring_to(phase_ff);
         extent   = (old_ring > new_ring) ? old_ring : new_ring;
      end
   end

   // One restoring step of the shared divider: 8 quotient bits in 8 steps.
   assign div_ge   = (rem_ff >= dsh_ff);
   assign div_done = (cnt_ff == 3'd7);

   // Rounded level product for the ring being scaled.
   assign scale_prod = 16'(active_level_ff) *
                       16'((state_ff == S_LOAD_OLD) ? old_mix_ff : mix_ff) + ROUND_BIAS;

   // Pixel level for the position being emitted.
   assign pix_ring = ring_of(pos_ff);
   always_comb begin
      if (pix_ring == old_ring) begin
         pix_white = old_w_ff;
      end else if (pix_ring == new_ring) begin
         pix_white = new_w_ff;
      end else if (pix_ring < extent) begin
         pix_white = inner_level_ff;
      end else begin
         pix_white = 8'd0;
      end
   end

   assign emit_load = (state_ff == S_EMIT) && (!rsp_valid_ff || !rsp_stall);
   assign fc_next   = {1'b0, fc_ff} + 17'd1;

   // Register writes.
   always_comb begin
      hold_frames_in  = hold_frames_ff;
      cross_frames_in = cross_frames_ff;
      active_level_in = active_level_ff;
      inner_level_in  = inner_level_ff;
      if (csr_take) begin
         case (csr_index)
            REG_HOLD_FRAMES:  hold_frames_in  = csr_data;
            REG_CROSS_FRAMES: cross_frames_in = csr_data;
            REG_ACTIVE_LEVEL: active_level_in = csr_data[7:0];
            REG_INNER_LEVEL:  inner_level_in  = csr_data[7:0];
            default:          hold_frames_in  = hold_frames_ff;
         endcase
      end
   end

   // Frame sequencer.
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      fc_in        = fc_ff;
      pos_in       = pos_ff;
      mix_in       = mix_ff;
      old_mix_in   = old_mix_ff;
      old_w_in     = old_w_ff;
      new_w_in     = new_w_ff;
      rem_in       = rem_ff;
      dsh_in       = dsh_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_index_in = rsp_index_ff;
      rsp_white_in = rsp_white_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         S_IDLE: begin
            // A request with the tick set starts a frame; the phase ends
            // at once when the frame count already reaches its length.
            if (req_take && req_frame_tick) begin
               if ({1'b0, fc_ff} >= phase_len(norm_phase, inner_eff, step_eff)) begin
                  phase_in = next_phase(norm_phase);
                  fc_in    = 16'd0;
               end else begin
                  phase_in = norm_phase;
               end
               state_in = S_MIX;
            end
         end
         S_MIX: begin
            if (!is_fade(phase_ff) && !is_hold(phase_ff)) begin
               // Crossfade mix is frame*255/step length on the divider.
               rem_in   = {fc_ff, 8'h00} - 24'(fc_ff);
               dsh_in   = {1'b0, step_eff, 7'd0};
               cnt_in   = 3'd0;
               state_in = S_DIV_MIX;
            end else begin
               mix_in     = is_fade(phase_ff) ? fade_mix : MIX_FULL;
               old_mix_in = 8'd0;
               state_in   = S_LOAD_OLD;
            end
         end
         S_LOAD_OLD, S_LOAD_NEW: begin
            // Rounded scale (level*mix+127)/255 on the divider.
            rem_in   = 24'(scale_prod);
            dsh_in   = 24'(MIX_FULL) << 7;
            cnt_in   = 3'd0;
            state_in = (state_ff == S_LOAD_OLD) ? S_DIV_OLD : S_DIV_NEW;
         end
         S_DIV_MIX, S_DIV_OLD, S_DIV_NEW: begin
            rem_in = div_ge ? rem_ff - dsh_ff : rem_ff;
            dsh_in = dsh_ff >> 1;
            quo_in = {quo_ff[6:0], div_ge};
            cnt_in = cnt_ff + 3'd1;
            if (div_done) begin
               if (state_ff == S_DIV_MIX) begin
                  mix_in     = quo_in;
                  old_mix_in = MIX_FULL - quo_in;
                  state_in   = S_LOAD_OLD;
               end else if (state_ff == S_DIV_OLD) begin
                  old_w_in = quo_in;
                  state_in = S_LOAD_NEW;
               end else begin
                  new_w_in = quo_in;
                  pos_in   = 6'd0;
                  state_in = S_EMIT;
               end
            end
         end
         S_EMIT: begin
            // One pixel per cycle into the output register while the result is not stalled.
            if (emit_load) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = pos_ff;
               rsp_white_in = pix_white;
               rsp_last_in  = (pos_ff == LAST_PIXEL);
               pos_in       = pos_ff + 6'd1;
               if (pos_ff == LAST_PIXEL) begin
                  // Count the frame and move on when the phase is complete.
                  if (fc_next >= phase_len(phase_ff, inner_eff, step_eff)) begin
                     phase_in = next_phase(phase_ff);
                     fc_in    = 16'd0;
                  end else begin
                     fc_in = fc_next[15:0];
                  end
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control and register state.
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_frames_ff  <= 16'd0;
         cross_frames_ff <= 16'd0;
         active_level_ff <= 8'd16;
         inner_level_ff  <= 8'd1;
         state_ff        <= S_IDLE;
         phase_ff        <= PH_FADE_IN;
         fc_ff           <= 16'd0;
         pos_ff          <= 6'd0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         hold_frames_ff  <= hold_frames_in;
         cross_frames_ff <= cross_frames_in;
         active_level_ff <= active_level_in;
         inner_level_ff  <= inner_level_in;
         state_ff        <= state_in;
         phase_ff        <= phase_in;
         fc_ff           <= fc_in;
         pos_ff          <= pos_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      mix_ff       <= mix_in;
      old_mix_ff   <= old_mix_in;
      old_w_ff     <= old_w_in;
      new_w_ff     <= new_w_in;
      rem_ff       <= rem_in;
      dsh_ff       <= dsh_in;
      quo_ff       <= quo_in;
      cnt_ff       <= cnt_in;
      rsp_index_ff <= rsp_index_in;
      rsp_white_ff <= rsp_white_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // The phase register never leaves the defined sequence.
   assert property (@(posedge clock) disable iff (reset) phase_ff <= PH_FADE_OUT)
      else $error("phase register outside the sequence");

   // A frame tick request always starts the mix setup.
   assert property (@(posedge clock) disable iff (reset)
                    req_take && req_frame_tick |=> state_ff == S_MIX)
      else $error("frame request did not start a frame");

   // Pixels leave in order, one position further each load.
   assert property (@(posedge clock) disable iff (reset)
                    emit_load && pos_ff != LAST_PIXEL |=> pos_ff == $past(pos_ff) + 6'd1)
      else $error("pixel position skipped");

   // The last flag marks exactly the final pixel.
   assert property (@(posedge clock) disable iff (reset)
                    emit_load |=> rsp_last_ff == (rsp_index_ff == LAST_PIXEL))
      else $error("last flag on wrong pixel");

endmodule
